// File: rtl/tph_pkg.sv
// ----------------------------------------------------------------------------
// tph_pkg
// Types, widths and helpers shared by the triangle plane height pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tph_pkg;

  localparam int CW     = 32;            // coordinate width, signed fixed point
  localparam int DIF_W  = CW + 1;        // vertex difference
  localparam int PR_W   = 2 * DIF_W;     // edge product
  localparam int NRM_W  = PR_W + 1;      // normal component
  localparam int LO_W   = NRM_W / 2;     // low slice of a split operand
  localparam int HI_W   = NRM_W - LO_W;  // high slice, signed
  localparam int PP_W   = LO_W + 1 + DIF_W; // partial product
  localparam int NUM_W  = NRM_W + DIF_W; // full product
  localparam int T_W    = NUM_W + 3;     // numerator with headroom
  localparam int QB     = CW - 1;        // quotient magnitude bits

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_z;
  } tph_in_t;

  typedef struct packed {
    logic signed [CW-1:0] height;
    logic                 degenerate;
    logic                 saturated;
  } tph_out_t;

  // one restoring division step travels as this bundle
  typedef struct packed {
    logic             valid;
    logic [T_W-1:0]   rem;
    logic [T_W-1:0]   ds;
    logic [CW-1:0]    q;
    logic             neg;
    logic             degen;
  } step_t;

  function automatic logic signed [DIF_W-1:0] sdiff(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
    logic signed [DIF_W-1:0] ea;
    logic signed [DIF_W-1:0] eb;
    ea = DIF_W'(a);
    eb = DIF_W'(b);
    return ea - eb;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tph_plane.sv
// ----------------------------------------------------------------------------
// tph_plane
// Normal, numerator and divider operands over seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tph_plane import tph_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire logic    in_vld,
  input  tph_in_t      in_req,
  output step_t        dout
);

  logic [5:0] vld_r;

  // stage 1: differences
  logic signed [DIF_W-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r, dqx1_r, dqz1_r;
  logic signed [CW-1:0]    v1y1_r;
  // stage 2: edge products
  logic signed [PR_W-1:0]  aybz_r, azby_r, azbx_r, axbz_r, axby_r, aybx_r;
  logic signed [DIF_W-1:0] dqx2_r, dqz2_r, v1y2_r;
  // stage 3: normal
  logic signed [NRM_W-1:0] nx_r, ny3_r, nz_r;
  logic signed [DIF_W-1:0] dqx3_r, dqz3_r, v1y3_r;
  // stage 4: partial products
  logic signed [PP_W-1:0]  pxl_r, pxh_r, pzl_r, pzh_r, pyl_r, pyh_r;
  logic signed [NRM_W-1:0] ny4_r;
  // stage 5: full products
  logic signed [NUM_W-1:0] px_r, py_r, pz_r;
  logic signed [NRM_W-1:0] ny5_r;
  // stage 6: numerator
  logic signed [T_W-1:0]   t_r;
  logic signed [NRM_W-1:0] ny6_r;
  // stage 7
  step_t                   out_r;

  logic signed [T_W-1:0]   tn;
  logic [NRM_W-1:0]        dmag;
  logic                    nyneg;

  function automatic logic signed [PP_W-1:0] mlo(input logic signed [NRM_W-1:0] a,
                                                 input logic signed [DIF_W-1:0] b);
    logic signed [LO_W:0] l;
    l = $signed({1'b0, a[LO_W-1:0]});
    return PP_W'(l) * PP_W'(b);
  endfunction

  function automatic logic signed [PP_W-1:0] mhi(input logic signed [NRM_W-1:0] a,
                                                 input logic signed [DIF_W-1:0] b);
    logic signed [HI_W-1:0] h;
    h = $signed(a[NRM_W-1:LO_W]);
    return PP_W'(h) * PP_W'(b);
  endfunction

  function automatic logic signed [NUM_W-1:0] mjoin(input logic signed [PP_W-1:0] h,
                                                    input logic signed [PP_W-1:0] l);
    logic signed [NUM_W-1:0] eh;
    logic signed [NUM_W-1:0] el;
    eh = NUM_W'(h);
    el = NUM_W'(l);
    return (eh <<< LO_W) + el;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r   <= sdiff(in_req.v1_x, in_req.v0_x);
      ay_r   <= sdiff(in_req.v1_y, in_req.v0_y);
      az_r   <= sdiff(in_req.v1_z, in_req.v0_z);
      bx_r   <= sdiff(in_req.v2_x, in_req.v1_x);
      by_r   <= sdiff(in_req.v2_y, in_req.v1_y);
      bz_r   <= sdiff(in_req.v2_z, in_req.v1_z);
      dqx1_r <= sdiff(in_req.query_x, in_req.v1_x);
      dqz1_r <= sdiff(in_req.query_z, in_req.v1_z);
      v1y1_r <= in_req.v1_y;

      aybz_r <= PR_W'(ay_r) * PR_W'(bz_r);
      azby_r <= PR_W'(az_r) * PR_W'(by_r);
      azbx_r <= PR_W'(az_r) * PR_W'(bx_r);
      axbz_r <= PR_W'(ax_r) * PR_W'(bz_r);
      axby_r <= PR_W'(ax_r) * PR_W'(by_r);
      aybx_r <= PR_W'(ay_r) * PR_W'(bx_r);
      dqx2_r <= dqx1_r;
      dqz2_r <= dqz1_r;
      v1y2_r <= DIF_W'(v1y1_r);

      nx_r   <= NRM_W'(aybz_r) - NRM_W'(azby_r);
      ny3_r  <= NRM_W'(azbx_r) - NRM_W'(axbz_r);
      nz_r   <= NRM_W'(axby_r) - NRM_W'(aybx_r);
      dqx3_r <= dqx2_r;
      dqz3_r <= dqz2_r;
      v1y3_r <= v1y2_r;

      pxl_r  <= mlo(nx_r, dqx3_r);
      pxh_r  <= mhi(nx_r, dqx3_r);
      pzl_r  <= mlo(nz_r, dqz3_r);
      pzh_r  <= mhi(nz_r, dqz3_r);
      pyl_r  <= mlo(ny3_r, v1y3_r);
      pyh_r  <= mhi(ny3_r, v1y3_r);
      ny4_r  <= ny3_r;

      px_r   <= mjoin(pxh_r, pxl_r);
      pz_r   <= mjoin(pzh_r, pzl_r);
      py_r   <= mjoin(pyh_r, pyl_r);
      ny5_r  <= ny4_r;

      t_r    <= T_W'(py_r) - T_W'(px_r) - T_W'(pz_r);
      ny6_r  <= ny5_r;
    end
  end

  // fold the divisor sign into the numerator, then floor by complement
  always_comb begin
    nyneg = ny6_r[NRM_W-1];
    tn    = nyneg ? -t_r : t_r;
    dmag  = nyneg ? NRM_W'(-ny6_r) : NRM_W'(ny6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r.valid <= vld_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.neg   <= tn[T_W-1];
      out_r.rem   <= T_W'(tn ^ {T_W{tn[T_W-1]}});
      out_r.ds    <= T_W'(dmag) << QB;
      out_r.q     <= '0;
      out_r.degen <= (ny6_r == '0);
    end
  end

  assign dout = out_r;

endmodule

`default_nettype wire

// File: rtl/tph_div_step.sv
// ----------------------------------------------------------------------------
// tph_div_step
// One registered restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tph_div_step import tph_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  step_t     din,
  output step_t     dout
);

  step_t step_r;
  logic  ge;

  assign ge = (din.rem >= din.ds);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r.valid <= 1'b0;
    end else if (adv) begin
      step_r.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step_r.rem   <= ge ? (din.rem - din.ds) : din.rem;
      step_r.ds    <= din.ds >> 1;
      step_r.q     <= {din.q[CW-2:0], ge};
      step_r.neg   <= din.neg;
      step_r.degen <= din.degen;
    end
  end

  assign dout = step_r;

endmodule

`default_nettype wire

// File: rtl/triangle_plane_height_core.sv
// throughput: one request per cycle; the whole pipeline holds while the result waits
// 7 arithmetic stages, 32 restoring divider stages (one quotient bit each), 1 output stage
// reset: synchronous rst_n clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// triangle_plane_height_core
// Floored plane height of a triangle above a query point, saturated; zero when degenerate.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_plane_height_core import tph_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  tph_in_t   in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output tph_out_t  out_data
);

  step_t     chain [CW+1];
  logic      adv;
  logic      out_valid_r;
  tph_out_t  out_data_r;
  tph_out_t  res;
  logic [CW-1:0] mag;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  tph_plane u_plane (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .in_req (in_data),
    .dout   (chain[0])
  );

  for (genvar g = 0; g < CW; g++) begin : g_div
    tph_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .din   (chain[g]),
      .dout  (chain[g+1])
    );
  end

  // top quotient bit marks overflow, negative side is the complement
  always_comb begin
    mag = {1'b0, chain[CW].q[QB-1:0]};
    res.degenerate = chain[CW].degen;
    res.saturated  = !chain[CW].degen && chain[CW].q[CW-1];
    if (chain[CW].degen) begin
      res.height = '0;
    end else if (chain[CW].q[CW-1]) begin
      res.height = chain[CW].neg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else begin
      res.height = chain[CW].neg ? ~mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[CW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.height == '0 && !out_data.saturated)
    else $error("degenerate result with nonzero height or saturation");

  a_sat_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.height == {1'b1, {QB{1'b0}}} || out_data.height == {1'b0, {QB{1'b1}}})
    else $error("saturated result not at a range bound");

  a_stall_src : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  a_reset_clr : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
